[sv/lswc_pkg.sv]
// Shared types and constants for the line segment window clip unit.
// Holds the sequencer state type, outcode bits and register indexes.
// No dependencies.
`default_nettype none

package lswc_pkg;

	// Sequencer states of the clip controller.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} state_t;

	// Outcode bits of one endpoint.
	localparam logic [3:0] CODE_TOP    = 4'h8;
	localparam logic [3:0] CODE_BOTTOM = 4'h4;
	localparam logic [3:0] CODE_RIGHT  = 4'h2;
	localparam logic [3:0] CODE_LEFT   = 4'h1;

	// Edge moves allowed before the segment is given up as rejected.
	localparam int MOVE_BITS = 3;
	localparam logic [MOVE_BITS-1:0] MAX_MOVES = 3'd4;

	// Configuration register indexes.
	localparam int REG_IDX_BITS = 2;
	localparam logic [REG_IDX_BITS-1:0] REG_X_LOW  = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_X_HIGH = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_Y_LOW  = 2'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_Y_HIGH = 2'd3;

	// Window reset values.
	localparam int WIN_LOW_RESET  = -100;
	localparam int WIN_HIGH_RESET = 100;

endpackage

`default_nettype wire

[sv/lswc_muldiv.sv]
// Iterative multiply-divide unit: base + span*num/den, quotient truncated toward zero.
// One bit of |span| is consumed per cycle; |num| is clamped to |den|.
// No package dependencies.
`default_nettype none

module lswc_muldiv #(
	parameter int W = 24
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic signed [W-1:0] base,
	input  wire logic signed [W-1:0] span,
	input  wire logic signed [W-1:0] num,
	input  wire logic signed [W-1:0] den,
	output logic                     done,
	output logic signed [W-1:0]      result,
	output logic                     busy
);

	localparam int RW = W + 2;
	localparam int AW = W - 1;
	localparam int CW = $clog2(AW);

	logic                 busy_q;
	logic                 fin_q;
	logic [CW-1:0]        cnt_q;
	logic [AW-1:0]        a_q;
	logic [W-1:0]         b_q;
	logic [W-1:0]         c_q;
	logic [W-1:0]         q_q;
	logic [RW-1:0]        r_q;
	logic                 neg_q;
	logic signed [W-1:0]  base_q;

	logic [W-1:0]  span_mag;
	logic [W-1:0]  num_mag;
	logic [W-1:0]  den_mag;
	logic [RW-1:0] r_sum;
	logic [RW-1:0] c_one;
	logic [RW-1:0] c_two;
	logic [RW-1:0] r_next;
	logic [1:0]    q_inc;

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		mag = v[W-1] ? W'(-v) : W'(v);
	endfunction

	assign span_mag = mag(span);
	assign num_mag  = mag(num);
	assign den_mag  = mag(den);

	// One step: shift the remainder, add the clamped numerator when the span bit
	// is set, then remove the divisor up to twice.
	always_comb begin
		r_sum = {r_q[RW-2:0], 1'b0} + (a_q[AW-1] ? RW'(b_q) : RW'(0));
		c_one = RW'(c_q);
		c_two = {1'b0, c_q, 1'b0};
		if (r_sum >= c_two) begin
			r_next = r_sum - c_two;
			q_inc  = 2'd2;
		end else if (r_sum >= c_one) begin
			r_next = r_sum - c_one;
			q_inc  = 2'd1;
		end else begin
			r_next = r_sum;
			q_inc  = 2'd0;
		end
	end

	// Control: busy while the span bits are worked through, then done is raised.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(AW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Operand and partial result registers.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= span_mag[AW-1:0];
			b_q    <= (num_mag > den_mag) ? den_mag : num_mag;
			c_q    <= den_mag;
			neg_q  <= span[W-1] ^ num[W-1] ^ den[W-1];
			base_q <= base;
			q_q    <= '0;
			r_q    <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[AW-2:0], 1'b0};
			q_q <= {q_q[W-2:0], 1'b0} + W'(q_inc);
			r_q <= r_next;
		end
	end

	// A zero divisor leaves the base unchanged.
	always_comb begin
		if (c_q == '0) begin
			result = base_q;
		end else if (neg_q) begin
			result = base_q - $signed(q_q);
		end else begin
			result = base_q + $signed(q_q);
		end
	end

	assign done = fin_q;
	assign busy = busy_q;

endmodule

`default_nettype wire

[sv/line_segment_window_clip_unit.sv]
// Top level of the line segment window clip unit (outcode-based line clipping).
// Depends on lswc_pkg and lswc_muldiv.
//
// Usage: a segment enters on the s_ channel as four signed coordinates and
// leaves on the m_ channel as the clipped segment, with the accept flag on
// m_tuser. A rejected segment returns all-zero coordinates. The window is
// written through cfg_we/cfg_index/cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce. s_tready is high
// only while no segment is in work. An item makes up to MAX_MOVES edge moves, each one
// pass of the shared multiply-divide unit, which takes one bit of the span per
// cycle. The output register holds the result until m_tready; a new item can be
// accepted meanwhile, and it waits in its final state if the register is full.
// Reset clears all control state and loads the window -100..100 on both axes.
`default_nettype none

module line_segment_window_clip_unit #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// Segment in.
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// s_tdata: start_x, start_y, end_x, end_y (lowest bits first)
	input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// Clipped segment out.
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// m_tdata: clip_start_x, clip_start_y, clip_end_x, clip_end_y (lowest bits first)
	output logic [((4*COORD_BITS+7)/8)*8-1:0] m_tdata,
	// m_tuser: accepted
	output logic [0:0]                      m_tuser,
	// Window configuration.
	input  wire logic                       cfg_we,
	input  wire logic [lswc_pkg::REG_IDX_BITS-1:0] cfg_index,
	input  wire logic [COORD_BITS-1:0]      cfg_wdata
);

	localparam int CB = COORD_BITS;
	localparam int W  = COORD_BITS + 8;
	localparam int DW = ((4*COORD_BITS+7)/8)*8;

	lswc_pkg::state_t state_q, state_d;

	logic [CB-1:0] win_xl_q, win_xh_q, win_yl_q, win_yh_q;
	logic signed [W-1:0] xl_w, xh_w, yl_w, yh_w;

	logic signed [W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic signed [W-1:0] edge_q;
	logic                vert_q;
	logic                sel_start_q;
	logic [lswc_pkg::MOVE_BITS-1:0] moves_q;
	logic                acc_q;

	logic          m_valid_q;
	logic          out_acc_q;
	logic [CB-1:0] out_sx_q, out_sy_q, out_ex_q, out_ey_q;

	logic [3:0] c1, c2, co;
	logic       co_vert;
	logic signed [W-1:0] edge_sel;
	logic signed [W-1:0] div_base, div_span, div_num, div_den;
	logic       div_start, div_done, div_busy;
	logic signed [W-1:0] div_result;
	logic       in_fire, out_load, trivial_acc, trivial_rej;

	function automatic logic signed [W-1:0] sx(input logic [CB-1:0] v);
		sx = {{(W-CB){v[CB-1]}}, v};
	endfunction

	function automatic logic [3:0] outcode(
		input logic signed [W-1:0] x,
		input logic signed [W-1:0] y,
		input logic signed [W-1:0] xl,
		input logic signed [W-1:0] xh,
		input logic signed [W-1:0] yl,
		input logic signed [W-1:0] yh
	);
		logic [3:0] c;
		c = 4'h0;
		if (x < xl) begin
			c = c | lswc_pkg::CODE_LEFT;
		end else if (x > xh) begin
			c = c | lswc_pkg::CODE_RIGHT;
		end
		if (y < yl) begin
			c = c | lswc_pkg::CODE_BOTTOM;
		end else if (y > yh) begin
			c = c | lswc_pkg::CODE_TOP;
		end
		outcode = c;
	endfunction

	// Window registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_xl_q <= CB'(lswc_pkg::WIN_LOW_RESET);
			win_xh_q <= CB'(lswc_pkg::WIN_HIGH_RESET);
			win_yl_q <= CB'(lswc_pkg::WIN_LOW_RESET);
			win_yh_q <= CB'(lswc_pkg::WIN_HIGH_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				lswc_pkg::REG_X_LOW:  win_xl_q <= cfg_wdata;
				lswc_pkg::REG_X_HIGH: win_xh_q <= cfg_wdata;
				lswc_pkg::REG_Y_LOW:  win_yl_q <= cfg_wdata;
				lswc_pkg::REG_Y_HIGH: win_yh_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign xl_w = sx(win_xl_q);
	assign xh_w = sx(win_xh_q);
	assign yl_w = sx(win_yl_q);
	assign yh_w = sx(win_yh_q);

	// Outcodes and the edge to move onto.
	always_comb begin
		c1 = outcode(x1_q, y1_q, xl_w, xh_w, yl_w, yh_w);
		c2 = outcode(x2_q, y2_q, xl_w, xh_w, yl_w, yh_w);
		co = (c1 != 4'h0) ? c1 : c2;
		co_vert = (co & (lswc_pkg::CODE_TOP | lswc_pkg::CODE_BOTTOM)) != 4'h0;
		if (co_vert) begin
			edge_sel = ((co & lswc_pkg::CODE_TOP) != 4'h0) ? yh_w : yl_w;
			div_base = x1_q;
			div_span = x2_q - x1_q;
			div_num  = edge_sel - y1_q;
			div_den  = y2_q - y1_q;
		end else begin
			edge_sel = ((co & lswc_pkg::CODE_LEFT) != 4'h0) ? xl_w : xh_w;
			div_base = y1_q;
			div_span = y2_q - y1_q;
			div_num  = edge_sel - x1_q;
			div_den  = x2_q - x1_q;
		end
		trivial_acc = (c1 | c2) == 4'h0;
		trivial_rej = ((c1 & c2) != 4'h0) || (moves_q == lswc_pkg::MAX_MOVES);
	end

	// Shared multiply-divide unit.
	lswc_muldiv #(
		.W(W)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.base   (div_base),
		.span   (div_span),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.result (div_result),
		.busy   (div_busy)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lswc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake controls.
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			lswc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = lswc_pkg::ST_CHECK;
				end
			end
			lswc_pkg::ST_CHECK: begin
				if (trivial_acc || trivial_rej) begin
					state_d = lswc_pkg::ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = lswc_pkg::ST_DIV;
				end
			end
			lswc_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = lswc_pkg::ST_CHECK;
				end
			end
			lswc_pkg::ST_DONE: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = lswc_pkg::ST_IDLE;
				end
			end
			default: state_d = lswc_pkg::ST_IDLE;
		endcase
	end

	assign in_fire = s_tvalid && s_tready;

	// Move counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moves_q <= '0;
		end else if (in_fire) begin
			moves_q <= '0;
		end else if (state_q == lswc_pkg::ST_DIV && div_done) begin
			moves_q <= moves_q + 1'b1;
		end
	end

	// Endpoint registers and the pending edge move.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x1_q <= sx(s_tdata[CB-1:0]);
			y1_q <= sx(s_tdata[2*CB-1:CB]);
			x2_q <= sx(s_tdata[3*CB-1:2*CB]);
			y2_q <= sx(s_tdata[4*CB-1:3*CB]);
		end else if (state_q == lswc_pkg::ST_CHECK) begin
			acc_q       <= trivial_acc;
			edge_q      <= edge_sel;
			vert_q      <= co_vert;
			sel_start_q <= c1 != 4'h0;
		end else if (state_q == lswc_pkg::ST_DIV && div_done) begin
			if (sel_start_q) begin
				x1_q <= vert_q ? div_result : edge_q;
				y1_q <= vert_q ? edge_q : div_result;
			end else begin
				x2_q <= vert_q ? div_result : edge_q;
				y2_q <= vert_q ? edge_q : div_result;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_acc_q <= acc_q;
			out_sx_q  <= acc_q ? x1_q[CB-1:0] : '0;
			out_sy_q  <= acc_q ? y1_q[CB-1:0] : '0;
			out_ex_q  <= acc_q ? x2_q[CB-1:0] : '0;
			out_ey_q  <= acc_q ? y2_q[CB-1:0] : '0;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tuser[0] = out_acc_q;
	assign m_tdata    = DW'({out_ey_q, out_ex_q, out_sy_q, out_sx_q});

`ifndef SYNTHESIS
	// An accepted item keeps the input closed on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("input ready right after an item was accepted");

	// The move count never passes its limit.
	a_move_limit: assert property (@(posedge clk) disable iff (!arst_n)
		moves_q <= lswc_pkg::MAX_MOVES)
		else $error("edge move count beyond limit");

	// The divider is only started when it is free.
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// A rejected segment leaves with zero coordinates.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("rejected segment with nonzero coordinates");
`endif

endmodule

`default_nettype wire
